// ===== hw/rtl/ikc_pkg.sv =====
// Shared types, widths, constants and helper functions for the inverse kinematics core.
// No dependencies; ikc_cordic, ikc_cosrule and the core in hw/rtl import this package.
`default_nettype none

package ikc_pkg;

   // Parameter defaults
   localparam int COORD_WIDTH_DEF   = 16;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // Fixed internal widths
   localparam int LEN_W      = 15;  // link lengths, unsigned Q11.4
   localparam int CRD_W      = 20;  // coordinates after guard shift
   localparam int CIN_W      = 33;  // CORDIC input vector components
   localparam int CXY_W      = 34;  // CORDIC working vector components
   localparam int ACC_W      = 34;  // Q30 angle accumulator
   localparam int SUM_W      = 37;  // Q30 sums of angles
   localparam int NUM_W      = 44;  // cosine rule numerator
   localparam int DEN_W      = 37;  // cosine rule denominator
   localparam int SQ_COORD_W = 40;  // radicand of the radius roots
   localparam int SQ_COS_W   = 60;  // radicand of the sine root

   localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 34'sd1686629713;
   localparam logic signed [SUM_W-1:0] PI_SUM      = 37'sd3373259426;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_UPPER_ARM = 2'd0,
      CSR_FOREARM   = 2'd1,
      CSR_WRIST     = 2'd2
   } csr_index_type;

   // floor(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] val;
      unique case (idx)
         0:  val = 30'd843314856;
         1:  val = 30'd497837829;
         2:  val = 30'd263043836;
         3:  val = 30'd133525158;
         4:  val = 30'd67021686;
         5:  val = 30'd33543515;
         6:  val = 30'd16775850;
         7:  val = 30'd8388437;
         8:  val = 30'd4194282;
         9:  val = 30'd2097149;
         10: val = 30'd1048575;
         11: val = 30'd524287;
         12: val = 30'd262143;
         13: val = 30'd131071;
         14: val = 30'd65535;
         15: val = 30'd32767;
         16: val = 30'd16383;
         17: val = 30'd8191;
         18: val = 30'd4095;
         19: val = 30'd2047;
         20: val = 30'd1023;
         21: val = 30'd511;
         22: val = 30'd255;
         23: val = 30'd127;
         24: val = 30'd63;
         25: val = 30'd31;
         26: val = 30'd15;
         27: val = 30'd7;
         28: val = 30'd3;
         29: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

   function automatic int sqrt_latency(input int in_width);
      return (in_width >> 1) + 1;
   endfunction

   function automatic int cordic_latency(input int stages);
      return stages + 3;
   endfunction

   function automatic int cosrule_latency(input int stages);
      return 3 + sqrt_latency(SQ_COS_W) + cordic_latency(stages);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ikc_delay.sv =====
// Fixed-length shift line that keeps side data aligned with the arithmetic cells.
// Depends on nothing but its parameters.
`default_nettype none

module ikc_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   // Advance the line every cycle
   always_ff @(posedge clock) begin
      line_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ikc_sqrt.sv =====
// Pipelined integer square root rounded to nearest, one result bit per cell.
// Depends on nothing but its parameters; a rounding register follows the last cell.
`default_nettype none

module ikc_sqrt #(
   parameter int IN_WIDTH = 40
) (
   input  logic                    clock,
   input  logic [IN_WIDTH-1:0]     din,
   output logic [IN_WIDTH/2:0]     root
);

   localparam int HALF = IN_WIDTH / 2;

   logic [IN_WIDTH-1:0] v_ff   [1:HALF];
   logic [IN_WIDTH-1:0] res_ff [1:HALF];
   logic [HALF:0]       root_ff;

   for (genvar j = 0; j < HALF; j++) begin : g_cell
      localparam int K = HALF - 1 - j;
      localparam logic [IN_WIDTH:0] BITV = (IN_WIDTH+1)'(1) << (2 * K);
      logic [IN_WIDTH-1:0] v_cur, res_cur, v_in, res_in;
      logic [IN_WIDTH:0]   trial;

      if (j == 0) begin : g_first
         assign v_cur   = din;
         assign res_cur = '0;
      end else begin : g_next
         assign v_cur   = v_ff[j];
         assign res_cur = res_ff[j];
      end

      // Try one result bit; subtract when it fits
      always_comb begin
         trial = {1'b0, res_cur} + BITV;
         if ({1'b0, v_cur} >= trial) begin
            v_in   = v_cur - trial[IN_WIDTH-1:0];
            res_in = (res_cur >> 1) + BITV[IN_WIDTH-1:0];
         end else begin
            v_in   = v_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[j+1]   <= v_in;
         res_ff[j+1] <= res_in;
      end
   end

   // Round to nearest
   always_ff @(posedge clock) begin
      root_ff <= (HALF+1)'(res_ff[HALF][HALF-1:0])
               + ((v_ff[HALF] > res_ff[HALF]) ? (HALF+1)'(1) : '0);
   end

   assign root = root_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ikc_cordic.sv =====
// Vectoring CORDIC: returns the Q30 angle of (x, y); zero vector gives zero.
// Depends on ikc_pkg; magnitude, normalize and quarter-turn registers precede the rotation cells.
`default_nettype none

module ikc_cordic import ikc_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic signed [CIN_W-1:0] x_in,
   input  logic signed [CIN_W-1:0] y_in,
   output logic signed [ACC_W-1:0] angle
);

   // Magnitude stage
   logic signed [CIN_W-1:0] x1_ff, y1_ff;
   logic [CIN_W-1:0]        m1_ff;
   logic signed [CIN_W:0]   xe, ye;
   logic [CIN_W-1:0]        ax, ay;

   always_comb begin
      xe = (CIN_W+1)'(x_in);
      ye = (CIN_W+1)'(y_in);
      ax = xe[CIN_W] ? CIN_W'(-xe) : CIN_W'(xe);
      ay = ye[CIN_W] ? CIN_W'(-ye) : CIN_W'(ye);
   end

   always_ff @(posedge clock) begin
      x1_ff <= x_in;
      y1_ff <= y_in;
      m1_ff <= (ax > ay) ? ax : ay;
   end

   // Normalize so the larger magnitude lies in [2^29, 2^30)
   logic [5:0]              msb;
   logic signed [63:0]      xw, yw, xs, ys;
   logic signed [CXY_W-1:0] x2_ff, y2_ff;
   logic                    zero2_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i < CIN_W; i++) begin
         if (m1_ff[i]) msb = 6'(i);
      end
      xw = 64'(x1_ff);
      yw = 64'(y1_ff);
      if (msb >= 6'd29) begin
         xs = xw >>> (msb - 6'd29);
         ys = yw >>> (msb - 6'd29);
      end else begin
         xs = xw <<< (6'd29 - msb);
         ys = yw <<< (6'd29 - msb);
      end
   end

   always_ff @(posedge clock) begin
      x2_ff    <= CXY_W'(xs);
      y2_ff    <= CXY_W'(ys);
      zero2_ff <= (m1_ff == '0);
   end

   // Turn a left half-plane vector by a quarter turn, then rotate in cells
   logic signed [CXY_W-1:0] x_ff    [0:STAGES];
   logic signed [CXY_W-1:0] y_ff    [0:STAGES];
   logic signed [ACC_W-1:0] a_ff    [0:STAGES];
   logic                    zero_ff [0:STAGES];

   always_ff @(posedge clock) begin
      zero_ff[0] <= zero2_ff;
      if (x2_ff < 0) begin
         if (y2_ff >= 0) begin
            x_ff[0] <= y2_ff;
            y_ff[0] <= -x2_ff;
            a_ff[0] <= HALF_PI_ACC;
         end else begin
            x_ff[0] <= -y2_ff;
            y_ff[0] <= x2_ff;
            a_ff[0] <= -HALF_PI_ACC;
         end
      end else begin
         x_ff[0] <= x2_ff;
         y_ff[0] <= y2_ff;
         a_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      localparam logic signed [ACC_W-1:0] STEP = $signed({4'b0, atan_q30(i)});
      logic signed [CXY_W-1:0] dx, dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      // Steer by the sign of y
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][CXY_W-1]) begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            a_ff[i+1] <= a_ff[i] + STEP;
         end else begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            a_ff[i+1] <= a_ff[i] - STEP;
         end
      end
   end

   assign angle = zero_ff[STAGES] ? '0 : a_ff[STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/ikc_cosrule.sv =====
// Cosine rule angle acos(num/den) as atan2(sqrt(den^2 - num^2), num), with a valid flag.
// Depends on ikc_pkg, ikc_sqrt, ikc_cordic and ikc_delay.
`default_nettype none

module ikc_cosrule import ikc_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic signed [ACC_W-1:0] angle,
   output logic                    ok
);

   localparam int LS  = sqrt_latency(SQ_COS_W);
   localparam int LC  = cordic_latency(CORDIC_STAGES);
   localparam int RW  = SQ_COS_W / 2 + 1;

   // Check range and scale den below 2^30
   logic [NUM_W-1:0] mag;
   logic [2:0]       k;
   logic [29:0]      d_ff, m_ff;
   logic             neg_ff, ok_ff;

   always_comb begin
      mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      k   = '0;
      for (int i = 30; i < DEN_W; i++) begin
         if (den[i]) k = 3'(i - 29);
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= 30'(den >> k);
      m_ff   <= 30'(mag >> k);
      neg_ff <= num[NUM_W-1];
      ok_ff  <= (den != '0) && (mag <= NUM_W'(den));
   end

   // Difference and sum
   logic [29:0]        dm_ff;
   logic [30:0]        dp_ff;
   logic signed [30:0] mx_ff;

   always_ff @(posedge clock) begin
      dm_ff <= d_ff - m_ff;
      dp_ff <= 31'(d_ff) + 31'(m_ff);
      mx_ff <= neg_ff ? -$signed(31'(m_ff)) : $signed(31'(m_ff));
   end

   // Radicand
   logic [SQ_COS_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= SQ_COS_W'(dm_ff * dp_ff);
   end

   logic [RW-1:0] s;

   ikc_sqrt #(.IN_WIDTH(SQ_COS_W)) u_sqrt (
      .clock (clock),
      .din   (prod_ff),
      .root  (s)
   );

   logic [30:0] mx_d;

   ikc_delay #(.WIDTH(31), .DEPTH(LS + 1)) u_mx_dly (
      .clock (clock),
      .din   (mx_ff),
      .dout  (mx_d)
   );

   ikc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock (clock),
      .x_in  (CIN_W'($signed(mx_d))),
      .y_in  ($signed(CIN_W'(s))),
      .angle (angle)
   );

   logic ok_d;

   ikc_delay #(.WIDTH(1), .DEPTH(2 + LS + LC)) u_ok_dly (
      .clock (clock),
      .din   (ok_ff),
      .dout  (ok_d)
   );

   assign ok = ok_d;

endmodule

`default_nettype wire

// ===== hw/rtl/three_joint_arm_inverse_kinematics_core.sv =====
// Inverse kinematics core for a rotating base with two planar links.
// Depends on ikc_pkg, ikc_delay, ikc_sqrt, ikc_cordic and ikc_cosrule.
//
// A target (x, y, z) is taken on any cycle in which start is high; busy
// stays low, so a new target may follow every clock. Each target yields one
// result, flagged by rsp_valid for a single cycle, once the transfer has
// passed the chain of square root cells (one per result bit) and CORDIC
// cells (one per micro-rotation) along the path radius, reach, cosine rule.
// The receiver cannot stall results. Write link lengths only while no target
// is in flight. Out-of-reach targets return reachable low and zero angles.
`default_nettype none

module three_joint_arm_inverse_kinematics_core import ikc_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_target_z,
   output logic                          rsp_valid,
   output logic signed [ANGLE_WIDTH-1:0] rsp_base_angle,
   output logic signed [ANGLE_WIDTH-1:0] rsp_shoulder_angle,
   output logic signed [ANGLE_WIDTH-1:0] rsp_elbow_angle,
   output logic                          rsp_reachable,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [LEN_W-1:0]              csr_wdata
);

   localparam int G       = (COORD_WIDTH > CRD_W) ? COORD_WIDTH - CRD_W : 0;
   localparam int LS      = sqrt_latency(SQ_COORD_W);
   localparam int LC      = cordic_latency(CORDIC_STAGES);
   localparam int LCR     = cosrule_latency(CORDIC_STAGES);
   localparam int RRW     = SQ_COORD_W / 2 + 1;
   localparam int T_R     = 3 + LS;
   localparam int T_RR    = T_R + 2 + LS;
   localparam int T_ANG   = T_RR + 2 + LCR;
   localparam int LAST    = T_ANG + 3;
   localparam int LATENCY = LAST + 1;
   localparam int SH      = 34 - ANGLE_WIDTH;

   assign busy = 1'b0;

   // Link length registers
   logic [LEN_W-1:0] l1_ff, l2_ff, l3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff <= '0;
         l2_ff <= '0;
         l3_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_UPPER_ARM: l1_ff <= csr_wdata;
            CSR_FOREARM:   l2_ff <= csr_wdata;
            CSR_WRIST:     l3_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [LEN_W-1:0] l1, l2, l3;
   assign l1 = l1_ff >> G;
   assign l2 = l2_ff >> G;
   assign l3 = l3_ff >> G;

   // Valid chain, one bit per pipeline step
   logic [LAST:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAST-1:0], start & ~busy};
      end
   end

   // Capture the transfer, dropping guard bits
   logic signed [CRD_W-1:0] x0_ff, y0_ff, z0_ff;

   always_ff @(posedge clock) begin
      x0_ff <= CRD_W'($signed(32'(req_target_x)) >>> G);
      y0_ff <= CRD_W'($signed(32'(req_target_y)) >>> G);
      z0_ff <= CRD_W'($signed(32'(req_target_z)) >>> G);
   end

   // Base angle atan2(x, y)
   logic signed [ACC_W-1:0] th0;

   ikc_cordic #(.STAGES(CORDIC_STAGES)) u_base_cordic (
      .clock (clock),
      .x_in  (CIN_W'(y0_ff)),
      .y_in  (CIN_W'(x0_ff)),
      .angle (th0)
   );

   // Horizontal radius
   logic [SQ_COORD_W-1:0] xx_ff, yy_ff, sxy_ff;

   always_ff @(posedge clock) begin
      xx_ff  <= SQ_COORD_W'(x0_ff * x0_ff);
      yy_ff  <= SQ_COORD_W'(y0_ff * y0_ff);
      sxy_ff <= xx_ff + yy_ff;
   end

   logic [RRW-1:0] rxy;

   ikc_sqrt #(.IN_WIDTH(SQ_COORD_W)) u_rxy_sqrt (
      .clock (clock),
      .din   (sxy_ff),
      .root  (rxy)
   );

   logic signed [RRW:0] r_ff;

   always_ff @(posedge clock) begin
      r_ff <= $signed({1'b0, rxy}) - $signed((RRW+1)'(l3));
   end

   logic [CRD_W-1:0] z_d;

   ikc_delay #(.WIDTH(CRD_W), .DEPTH(T_R)) u_z_dly (
      .clock (clock),
      .din   (z0_ff),
      .dout  (z_d)
   );

   // Elevation atan2(z, r)
   logic signed [ACC_W-1:0] p;

   ikc_cordic #(.STAGES(CORDIC_STAGES)) u_elev_cordic (
      .clock (clock),
      .x_in  (CIN_W'(r_ff)),
      .y_in  (CIN_W'($signed(z_d))),
      .angle (p)
   );

   // Reach
   logic [SQ_COORD_W-1:0] rsq_ff, zsq_ff, srz_ff;

   always_ff @(posedge clock) begin
      rsq_ff <= SQ_COORD_W'(r_ff * r_ff);
      zsq_ff <= SQ_COORD_W'($signed(z_d) * $signed(z_d));
      srz_ff <= rsq_ff + zsq_ff;
   end

   logic [RRW-1:0] rr;

   ikc_sqrt #(.IN_WIDTH(SQ_COORD_W)) u_rr_sqrt (
      .clock (clock),
      .din   (srz_ff),
      .root  (rr)
   );

   // Cosine rule products, then numerators and denominators
   logic [2*RRW-1:0]       rr2_ff;
   logic [LEN_W+RRW-1:0]   l1rr_ff;
   logic [2*LEN_W-1:0]     l1sq_ff, l2sq_ff, l1l2_ff;

   always_ff @(posedge clock) begin
      rr2_ff  <= rr * rr;
      l1rr_ff <= l1 * rr;
      l1sq_ff <= l1 * l1;
      l2sq_ff <= l2 * l2;
      l1l2_ff <= l1 * l2;
   end

   logic signed [NUM_W-1:0] num_b_ff, num_c_ff;
   logic [DEN_W-1:0]        den_b_ff, den_c_ff;

   always_ff @(posedge clock) begin
      num_b_ff <= $signed(NUM_W'(l1sq_ff)) + $signed(NUM_W'(rr2_ff))
                - $signed(NUM_W'(l2sq_ff));
      num_c_ff <= $signed(NUM_W'(l1sq_ff)) + $signed(NUM_W'(l2sq_ff))
                - $signed(NUM_W'(rr2_ff));
      den_b_ff <= DEN_W'({l1rr_ff, 1'b0});
      den_c_ff <= DEN_W'({l1l2_ff, 1'b0});
   end

   logic signed [ACC_W-1:0] b, c;
   logic                    ok_b, ok_c;

   ikc_cosrule #(.CORDIC_STAGES(CORDIC_STAGES)) u_cos_b (
      .clock (clock),
      .num   (num_b_ff),
      .den   (den_b_ff),
      .angle (b),
      .ok    (ok_b)
   );

   ikc_cosrule #(.CORDIC_STAGES(CORDIC_STAGES)) u_cos_c (
      .clock (clock),
      .num   (num_c_ff),
      .den   (den_c_ff),
      .angle (c),
      .ok    (ok_c)
   );

   // Align base and elevation angles with the cosine rule results
   logic [ACC_W-1:0] th0_d, p_d;

   ikc_delay #(.WIDTH(ACC_W), .DEPTH(T_ANG - LC)) u_th0_dly (
      .clock (clock),
      .din   (th0),
      .dout  (th0_d)
   );

   ikc_delay #(.WIDTH(ACC_W), .DEPTH(T_ANG - T_R - LC)) u_p_dly (
      .clock (clock),
      .din   (p),
      .dout  (p_d)
   );

   // Sum angles in Q30
   logic signed [SUM_W-1:0] a1_ff, c1_ff, th1_ff, a1b_ff, a2_ff, th2_ff;
   logic                    ok1_ff, ok2_ff;

   always_ff @(posedge clock) begin
      a1_ff  <= SUM_W'($signed(p_d)) + SUM_W'(b);
      c1_ff  <= SUM_W'(c);
      th1_ff <= SUM_W'($signed(th0_d));
      ok1_ff <= ok_b & ok_c;
      a2_ff  <= c1_ff + a1_ff - PI_SUM;
      a1b_ff <= a1_ff;
      th2_ff <= th1_ff;
      ok2_ff <= ok1_ff;
   end

   // Round half up to the output format and gate unreachable results
   logic signed [SUM_W-1:0] q_th, q_a1, q_a2;

   always_comb begin
      q_th = (th2_ff + (SUM_W'(1) <<< (SH - 1))) >>> SH;
      q_a1 = (a1b_ff + (SUM_W'(1) <<< (SH - 1))) >>> SH;
      q_a2 = (a2_ff  + (SUM_W'(1) <<< (SH - 1))) >>> SH;
   end

   always_ff @(posedge clock) begin
      rsp_base_angle     <= ok2_ff ? q_th[ANGLE_WIDTH-1:0] : '0;
      rsp_shoulder_angle <= ok2_ff ? q_a1[ANGLE_WIDTH-1:0] : '0;
      rsp_elbow_angle    <= ok2_ff ? q_a2[ANGLE_WIDTH-1:0] : '0;
      rsp_reachable      <= ok2_ff;
   end

   assign rsp_valid = valid_ff[LAST];

   // Checks
   ap_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result strobe missing after fixed latency");

   ap_unreachable_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reachable) |->
         (rsp_base_angle == '0 && rsp_shoulder_angle == '0 && rsp_elbow_angle == '0))
      else $error("unreachable result carries nonzero angles");

   ap_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

`default_nettype wire
